// ----- rtl/etf_pkg.sv -----
// Shared types, constants and helper functions of the escape-time fractal iterator.
// No dependencies; every other file imports it.
package etf_pkg;

    localparam int DEF_MAX_RESOLUTION  = 4096;
    localparam int DEF_COORD_FRAC_BITS = 26;
    localparam int DEF_ITER_WIDTH      = 16;

    // Mapping datapath widths: |span * (2p - w)| < 2^44, divisor 2h <= 8192.
    localparam int NUM_W = 45;
    localparam int DEN_W = 14;
    localparam int WIDE_W = 68;

    // Configuration register indexes.
    localparam logic [2:0] REG_CENTER_X   = 3'd0;
    localparam logic [2:0] REG_CENTER_Y   = 3'd1;
    localparam logic [2:0] REG_SPAN       = 3'd2;
    localparam logic [2:0] REG_WIDTH      = 3'd3;
    localparam logic [2:0] REG_HEIGHT     = 3'd4;
    localparam logic [2:0] REG_ITER_LIMIT = 3'd5;
    localparam logic [2:0] REG_VARIANT    = 3'd6;

    // Fractal variants.
    localparam logic [1:0] VAR_MANDEL  = 2'd0;
    localparam logic [1:0] VAR_TRICORN = 2'd1;
    localparam logic [1:0] VAR_SHIP    = 2'd2;
    localparam logic [1:0] VAR_JULIA   = 2'd3;

    typedef struct packed {
        logic signed [31:0] c_re;
        logic signed [31:0] c_im;
    } t_point;

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(64'sh7FFFFFFF);
        lo = -WIDE_W'(64'sh80000000);
        if (v > hi) sat32 = 32'sh7FFFFFFF;
        else if (v < lo) sat32 = 32'sh80000000;
        else sat32 = v[31:0];
    endfunction

    function automatic logic [12:0] eff_res(input logic [12:0] r, input logic [16:0] lim);
        if (r == 13'd0) eff_res = 13'd1;
        else if ({4'd0, r} > lim) eff_res = lim[12:0];
        else eff_res = r;
    endfunction

endpackage

// ----- rtl/etf_front.sv -----
// Front end: accepts a pixel and maps it into the complex plane.
// Two parallel multiplies, then a bit-serial restoring divide by 2*height. Uses etf_pkg.
module etf_front import etf_pkg::*; #(
    parameter int MAX_RESOLUTION = DEF_MAX_RESOLUTION
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [11:0]        i_pixel_x,
    input  logic [11:0]        i_pixel_y,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic [30:0]        i_span,
    input  logic [12:0]        i_width,
    input  logic [12:0]        i_height,
    output logic               o_q_push,
    input  logic               i_q_full,
    output t_point             o_q_data
);
    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MUL  = 3'd1;
    localparam logic [2:0] F_DIV  = 3'd2;
    localparam logic [2:0] F_FIN  = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;
    localparam logic [16:0] RES_LIM = 17'(MAX_RESOLUTION);

    logic [2:0]  r_state;
    logic [5:0]  r_step;
    logic [11:0] r_px, r_py;
    logic [12:0] r_w, r_h;
    logic [NUM_W-1:0] r_num_re, r_num_im;
    logic [DEN_W-1:0] r_rem_re, r_rem_im;
    logic r_neg_re, r_neg_im;
    t_point r_pt;

    logic signed [13:0] diff_re, diff_im;
    logic signed [45:0] prod_re, prod_im;
    logic [DEN_W-1:0] den;
    logic [DEN_W:0] sh_re, sh_im, tr_re, tr_im;
    logic signed [WIDE_W-1:0] q_re, q_im;

    assign diff_re = $signed({1'b0, r_px, 1'b0}) - $signed({1'b0, r_w});
    assign diff_im = $signed({1'b0, r_py, 1'b0}) - $signed({1'b0, r_h});
    assign prod_re = $signed({1'b0, i_span}) * diff_re;
    assign prod_im = $signed({1'b0, i_span}) * diff_im;
    assign den = {r_h, 1'b0};

    // One restoring step per cycle for both coordinates.
    assign sh_re = {r_rem_re, r_num_re[NUM_W-1]};
    assign sh_im = {r_rem_im, r_num_im[NUM_W-1]};
    assign tr_re = sh_re - {1'b0, den};
    assign tr_im = sh_im - {1'b0, den};

    // Floor division: a negative quotient with a remainder rounds one further down.
    always_comb begin
        q_re = WIDE_W'({1'b0, r_num_re});
        q_im = WIDE_W'({1'b0, r_num_im});
        if (r_neg_re) q_re = -(q_re + WIDE_W'(r_rem_re != '0));
        if (r_neg_im) q_im = -(q_im + WIDE_W'(r_rem_im != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        r_px    <= i_pixel_x;
                        r_py    <= i_pixel_y;
                        r_w     <= eff_res(i_width, RES_LIM);
                        r_h     <= eff_res(i_height, RES_LIM);
                        r_state <= F_MUL;
                    end
                end
                F_MUL: begin
                    r_neg_re <= prod_re[45];
                    r_neg_im <= prod_im[45];
                    r_num_re <= prod_re[45] ? NUM_W'(-prod_re) : NUM_W'(prod_re);
                    r_num_im <= prod_im[45] ? NUM_W'(-prod_im) : NUM_W'(prod_im);
                    r_rem_re <= '0;
                    r_rem_im <= '0;
                    r_step   <= '0;
                    r_state  <= F_DIV;
                end
                F_DIV: begin
                    if (!tr_re[DEN_W]) begin
                        r_rem_re <= tr_re[DEN_W-1:0];
                        r_num_re <= {r_num_re[NUM_W-2:0], 1'b1};
                    end else begin
                        r_rem_re <= sh_re[DEN_W-1:0];
                        r_num_re <= {r_num_re[NUM_W-2:0], 1'b0};
                    end
                    if (!tr_im[DEN_W]) begin
                        r_rem_im <= tr_im[DEN_W-1:0];
                        r_num_im <= {r_num_im[NUM_W-2:0], 1'b1};
                    end else begin
                        r_rem_im <= sh_im[DEN_W-1:0];
                        r_num_im <= {r_num_im[NUM_W-2:0], 1'b0};
                    end
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'(NUM_W - 1)) r_state <= F_FIN;
                end
                F_FIN: begin
                    r_pt.c_re <= sat32(WIDE_W'(i_center_x) + q_re);
                    r_pt.c_im <= sat32(WIDE_W'(i_center_y) + q_im);
                    r_state   <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_q_full) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_full   = (r_state != F_IDLE);
    assign o_q_push = (r_state == F_PUSH) && !i_q_full;
    assign o_q_data = r_pt;
endmodule

// ----- rtl/etf_queue.sv -----
// Two-entry queue of mapped points between the front end and the iterator.
// Uses etf_pkg for the point type.
module etf_queue import etf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    output logic   o_full,
    input  t_point i_data,
    input  logic   i_pop,
    output logic   o_empty,
    output t_point o_data
);
    t_point     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign do_push = i_push && (r_cnt != 2'd2);
    assign do_pop  = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
endmodule

// ----- rtl/etf_iter.sv -----
// Back end: runs the escape-time loop on one mapped point and holds the result.
// Each map step is a square state followed by an update state. Uses etf_pkg.
module etf_iter import etf_pkg::*; #(
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
    parameter int ITER_WIDTH      = DEF_ITER_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_variant,
    input  logic [15:0]        i_iter_limit,
    input  logic               i_q_empty,
    input  t_point             i_q_data,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [15:0]        o_iterations,
    output logic               o_escaped,
    output logic signed [31:0] o_final_re,
    output logic signed [31:0] o_final_im
);
    localparam int F = COORD_FRAC_BITS;
    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_MUL  = 2'd1;
    localparam logic [1:0] B_STEP = 2'd2;
    localparam logic [1:0] B_DONE = 2'd3;
    localparam bit NEVER_OUT = (2 * F + 2 > 63);
    localparam logic [66:0] THRESH = NEVER_OUT ? '0 : (67'd4 << (2 * F));
    localparam longint K_RE_RAW = -(((64'sd8 <<< F) + 64'sd5) / 64'sd10);
    localparam longint K_IM_RAW = ((64'sd4 <<< F) + 64'sd5) / 64'sd10;
    localparam logic signed [31:0] K_RE = sat32(WIDE_W'(K_RE_RAW));
    localparam logic signed [31:0] K_IM = sat32(WIDE_W'(K_IM_RAW));
    localparam logic [15:0] IT_MASK =
        (ITER_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << ITER_WIDTH) - 32'd1);

    logic [1:0] r_state;
    logic [1:0] r_var;
    logic [15:0] r_lim, r_cnt;
    logic signed [31:0] r_re, r_im, r_kre, r_kim;
    logic signed [65:0] r_aa, r_bb, r_ab;
    logic r_esc;

    logic signed [32:0] a, b;
    logic [66:0] mag;
    logic in_disk;
    logic signed [66:0] dre;
    logic signed [WIDE_W-1:0] nre, nim;

    always_comb begin
        a = 33'(r_re);
        b = 33'(r_im);
        if (r_var == VAR_TRICORN) b = -b;
        else if (r_var == VAR_SHIP) begin
            if (a < 0) a = -a;
            if (b < 0) b = -b;
        end
    end

    assign mag     = 67'(unsigned'(r_aa)) + 67'(unsigned'(r_bb));
    assign in_disk = NEVER_OUT || (mag <= THRESH);
    assign dre     = 67'(r_aa) - 67'(r_bb);
    assign nre     = WIDE_W'(dre >>> F) + WIDE_W'(r_kre);
    assign nim     = WIDE_W'(r_ab >>> (F - 1)) + WIDE_W'(r_kim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_var <= i_variant;
                        r_lim <= i_iter_limit;
                        r_cnt <= '0;
                        if (i_variant == VAR_JULIA) begin
                            r_kre <= K_RE;
                            r_kim <= K_IM;
                            r_re  <= i_q_data.c_re;
                            r_im  <= i_q_data.c_im;
                        end else begin
                            r_kre <= i_q_data.c_re;
                            r_kim <= i_q_data.c_im;
                            r_re  <= '0;
                            r_im  <= '0;
                        end
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_aa    <= a * a;
                    r_bb    <= b * b;
                    r_ab    <= a * b;
                    r_state <= B_STEP;
                end
                B_STEP: begin
                    if (in_disk && (r_cnt < r_lim)) begin
                        r_re    <= sat32(nre);
                        r_im    <= sat32(nim);
                        r_cnt   <= r_cnt + 16'd1;
                        r_state <= B_MUL;
                    end else begin
                        r_esc   <= !in_disk;
                        r_state <= B_DONE;
                    end
                end
                B_DONE: begin
                    if (i_pop) r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_q_pop      = (r_state == B_IDLE) && !i_q_empty;
    assign o_empty      = (r_state != B_DONE);
    assign o_iterations = r_cnt & IT_MASK;
    assign o_escaped    = r_esc;
    assign o_final_re   = r_re;
    assign o_final_im   = r_im;
endmodule

// ----- rtl/escape_time_fractal_iterator_core.sv -----
// Escape-time fractal iterator core (Mandelbrot, Tricorn, Burning Ship, Julia in Q6.26).
// A pixel passes through the front end (multiply, 45-step divide, final add), the queue and
// the iterator, which squares and then updates for every map step and ends with an escape check.
// Throughput is set by the squaring unit for long orbits and by the 45-step divider of the
// front end for short ones.
// Synchronous active-low reset restores all configuration defaults and empties the pipe.
module escape_time_fractal_iterator_core import etf_pkg::*; #(
    parameter int MAX_RESOLUTION  = DEF_MAX_RESOLUTION,
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
    parameter int ITER_WIDTH      = DEF_ITER_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [11:0]        i_pixel_x,
    input  logic [11:0]        i_pixel_y,
    output logic               empty,
    input  logic               pop,
    output logic [15:0]        o_iterations,
    output logic               o_escaped,
    output logic signed [31:0] o_final_re,
    output logic signed [31:0] o_final_im,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    // Configuration registers: the user must write them only while the block is idle.
    // The block does not enforce this. etf_front and etf_iter take their view from here.
    logic signed [31:0] r_center_x, r_center_y;
    logic [30:0] r_span;
    logic [12:0] r_width, r_height;
    logic [15:0] r_iter_limit;
    logic [1:0]  r_variant;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x   <= -32'sd46976204;
            r_center_y   <= 32'sd0;
            r_span       <= 31'd201326592;
            r_width      <= 13'd1024;
            r_height     <= 13'd1024;
            r_iter_limit <= 16'd256;
            r_variant    <= VAR_MANDEL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CENTER_X:   r_center_x   <= i_cfg_data;
                REG_CENTER_Y:   r_center_y   <= i_cfg_data;
                REG_SPAN:       r_span       <= i_cfg_data[30:0];
                REG_WIDTH:      r_width      <= i_cfg_data[12:0];
                REG_HEIGHT:     r_height     <= i_cfg_data[12:0];
                REG_ITER_LIMIT: r_iter_limit <= i_cfg_data[15:0];
                REG_VARIANT:    r_variant    <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // The front end turns each pixel beat into a point of the complex plane.
    logic   fq_push, fq_full, qb_pop, qb_empty;
    t_point fq_data, qb_data;

    etf_front #(.MAX_RESOLUTION(MAX_RESOLUTION)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_pixel_x  (i_pixel_x),
        .i_pixel_y  (i_pixel_y),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_span     (r_span),
        .i_width    (r_width),
        .i_height   (r_height),
        .o_q_push   (fq_push),
        .i_q_full   (fq_full),
        .o_q_data   (fq_data)
    );

    // The short queue lets the front end run ahead while the iterator is busy.
    etf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .o_full  (fq_full),
        .i_data  (fq_data),
        .i_pop   (qb_pop),
        .o_empty (qb_empty),
        .o_data  (qb_data)
    );

    // The iterator runs the map and holds the finished result until it is popped.
    etf_iter #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .ITER_WIDTH      (ITER_WIDTH)
    ) u_iter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_variant    (r_variant),
        .i_iter_limit (r_iter_limit),
        .i_q_empty    (qb_empty),
        .i_q_data     (qb_data),
        .o_q_pop      (qb_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_iterations (o_iterations),
        .o_escaped    (o_escaped),
        .o_final_re   (o_final_re),
        .o_final_im   (o_final_im)
    );
endmodule

// ----- rtl/etf_chk.sv -----
// Port-level checker for the escape-time fractal iterator, bound to the top level.
// Depends on escape_time_fractal_iterator_core and etf_pkg.
module etf_chk import etf_pkg::*; #(
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic [15:0]        o_iterations,
    input logic               o_escaped,
    input logic signed [31:0] o_final_re,
    input logic signed [31:0] o_final_im
);
    localparam bit BOUNDED = (COORD_FRAC_BITS < 30);
    localparam logic signed [31:0] LIM = BOUNDED ? (32'sd2 <<< COORD_FRAC_BITS) : '0;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queue not idle after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> full)
        else $error("front end took a beat without going busy");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_iterations) && $stable(o_final_re)))
        else $error("waiting result changed");

    a_inside_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (BOUNDED && !empty && !o_escaped) |->
        (o_final_re <= LIM && o_final_re >= -LIM && o_final_im <= LIM && o_final_im >= -LIM))
        else $error("point inside the disk lies outside radius two");
endmodule

bind escape_time_fractal_iterator_core etf_chk #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_iterations (o_iterations),
    .o_escaped    (o_escaped),
    .o_final_re   (o_final_re),
    .o_final_im   (o_final_im)
);

// ----- bench/tb.sv -----
// Self-checking testbench of the escape-time fractal iterator core.
// Depends on rtl/etf_pkg.sv and rtl/escape_time_fractal_iterator_core.sv.
`timescale 1ns / 1ps

// Holds the view registers as the block sees them, works out the escape-time
// result of every accepted pixel, and compares the beats that come back.
class orbit_scoreboard;
    typedef struct {
        bit [15:0]        iters;
        bit               esc;
        bit signed [31:0] re;
        bit signed [31:0] im;
    } orbit_t;

    orbit_t pending_q[$];
    int     errors;

    longint cx, cy, span;
    int     width, height, iter_limit;
    bit [1:0] variant;

    function new();
        errors = 0;
        cx = -46976204;
        cy = 0;
        span = 201326592;
        width = 1024;
        height = 1024;
        iter_limit = 256;
        variant = etf_pkg::VAR_MANDEL;
    endfunction

    function void write_reg(bit [2:0] idx, bit [31:0] data);
        case (idx)
            etf_pkg::REG_CENTER_X:   cx = longint'(signed'(data));
            etf_pkg::REG_CENTER_Y:   cy = longint'(signed'(data));
            etf_pkg::REG_SPAN:       span = longint'(data[30:0]);
            etf_pkg::REG_WIDTH:      width = int'(data[12:0]);
            etf_pkg::REG_HEIGHT:     height = int'(data[12:0]);
            etf_pkg::REG_ITER_LIMIT: iter_limit = int'(data[15:0]);
            etf_pkg::REG_VARIANT:    variant = data[1:0];
            default: ;
        endcase
    endfunction

    static function longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    static function longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    static function int clip_res(int r);
        if (r == 0) return 1;
        if (r > 4096) return 4096;
        return r;
    endfunction

    // True while |z| <= 2, judged on the exact squared magnitude.
    static function bit bounded(longint re, longint im);
        bit [63:0] a, b;
        a = (re < 0) ? -re : re;
        b = (im < 0) ? -im : im;
        return (a * a + b * b) <= (64'd4 << 52);
    endfunction

    function void note_pixel(bit [11:0] px, bit [11:0] py);
        longint w, h, pt_re, pt_im, k_re, k_im, re, im, a, b, nre;
        int     count;
        orbit_t r;
        w = clip_res(width);
        h = clip_res(height);
        pt_re = clamp32(cx + floor_div(span * (2 * longint'(px) - w), 2 * h));
        pt_im = clamp32(cy + floor_div(span * (2 * longint'(py) - h), 2 * h));
        if (variant == etf_pkg::VAR_JULIA) begin
            // Julia constant -0.8 + 0.4i, rounded to nearest in Q6.26.
            k_re = -(((64'sd8 << 26) + 5) / 10);
            k_im = ((64'sd4 << 26) + 5) / 10;
            re = pt_re;
            im = pt_im;
        end else begin
            k_re = pt_re;
            k_im = pt_im;
            re = 0;
            im = 0;
        end
        count = 0;
        while (bounded(re, im) && count < iter_limit) begin
            a = re;
            b = im;
            if (variant == etf_pkg::VAR_TRICORN) begin
                b = -b;
            end else if (variant == etf_pkg::VAR_SHIP) begin
                if (a < 0) a = -a;
                if (b < 0) b = -b;
            end
            nre = clamp32(((a * a - b * b) >>> 26) + k_re);
            im = clamp32(((a * b) >>> 25) + k_im);
            re = nre;
            count++;
        end
        r.iters = count[15:0];
        r.esc = !bounded(re, im);
        r.re = re[31:0];
        r.im = im[31:0];
        pending_q.push_back(r);
    endfunction

    function void check_result(bit [15:0] iters, bit esc, bit signed [31:0] re,
                               bit signed [31:0] im);
        orbit_t e;
        if (pending_q.size() == 0) begin
            $display("%0t: result beat with nothing outstanding: iters %0d", $time, iters);
            errors++;
            return;
        end
        e = pending_q.pop_front();
        if (e.iters != iters) begin
            $display("%0t: iterations expected %0d actual %0d", $time, e.iters, iters);
            errors++;
        end
        if (e.esc != esc) begin
            $display("%0t: escaped expected %0d actual %0d", $time, e.esc, esc);
            errors++;
        end
        if (e.re != re) begin
            $display("%0t: final_re expected %0d actual %0d", $time, e.re, re);
            errors++;
        end
        if (e.im != im) begin
            $display("%0t: final_im expected %0d actual %0d", $time, e.im, im);
            errors++;
        end
    endfunction
endclass

module tb import etf_pkg::*;;

    // Long enough for two full-limit orbits plus the whole random part at its
    // slowest stall settings, several times over.
    localparam int CYCLE_LIMIT = 4_000_000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [11:0]        i_pixel_x = '0;
    logic [11:0]        i_pixel_y = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [15:0]        o_iterations;
    logic               o_escaped;
    logic signed [31:0] o_final_re;
    logic signed [31:0] o_final_im;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_data = '0;

    orbit_scoreboard sb = new();

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int cycle_count = 0;

    escape_time_fractal_iterator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_pixel_x   (i_pixel_x),
        .i_pixel_y   (i_pixel_y),
        .empty       (empty),
        .pop         (pop),
        .o_iterations(o_iterations),
        .o_escaped   (o_escaped),
        .o_final_re  (o_final_re),
        .o_final_im  (o_final_im),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // The cycle counter is the only guard against a hung block.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("escape_time_fractal_iterator_core regression: fail");
            $finish;
        end
    end

    // Result side: a beat is taken at an edge where pop was high and empty low.
    // The values read here are the ones the edge itself saw. The next pop is
    // chosen from the current stall setting.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_result(o_iterations, o_escaped, o_final_re, o_final_im);
        pop <= i_rst_n && ($urandom_range(99) >= pop_stall_pct);
    end

    // Writes all seven view registers back to back. The write enable is raised
    // once and lowered once, so no edge sees two assignments to it.
    task automatic set_view(input logic [31:0] cx, input logic [31:0] cy,
                            input logic [31:0] span, input logic [31:0] w,
                            input logic [31:0] h, input logic [31:0] iters,
                            input logic [1:0] variant);
        logic [31:0] vals[7];
        logic [2:0]  idx_list[7];
        vals = '{cx, cy, span, w, h, iters, {30'd0, variant}};
        idx_list = '{REG_CENTER_X, REG_CENTER_Y, REG_SPAN, REG_WIDTH, REG_HEIGHT,
                     REG_ITER_LIMIT, REG_VARIANT};
        for (int i = 0; i < 7; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx_list[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            sb.write_reg(idx_list[i], vals[i]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one pixel and returns at the edge that accepted it. Push is left
    // high so that a back-to-back pixel needs no second assignment that step.
    task automatic send_pixel(input logic [11:0] px, input logic [11:0] py);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        do @(posedge i_clk); while (full);
        sb.note_pixel(px, py);
    endtask

    // Waits out every outstanding result, then lets the pipe settle before a
    // register write.
    task automatic drain();
        push <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_center();
        // Mostly near the interesting region, sometimes anywhere at all.
        if ($urandom_range(9) == 0) return $urandom();
        return 32'($signed($urandom_range(268435456)) - 134217728);
    endfunction

    initial begin
        logic [11:0] corner[4];
        logic [31:0] span_r;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: pixels at the ends and inside of the pixel range in every
        // variant with the reset view but an iteration limit of 64.
        corner = '{12'd0, 12'd4095, 12'd512, 12'd2048};
        for (int v = 0; v < 4; v++) begin
            set_view(32'hFD333334, 32'd0, 32'd201326592, 32'd1024, 32'd1024, 32'd64,
                     2'(v));
            send_pixel(corner[v], corner[3 - v]);
            send_pixel(corner[3 - v], corner[v]);
            drain();
        end

        // Zero width and a height above the limit, both clipped.
        set_view(32'd0, 32'd0, 32'd134217728, 32'd0, 32'd8191, 32'd40, VAR_MANDEL);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        drain();

        // Zero span puts every pixel on the centre; centres at the extremes and
        // the largest span push the mapping and the orbit into saturation.
        set_view(32'h7FFFFFFF, 32'h80000000, 32'd0, 32'd8191, 32'd1, 32'd5, VAR_SHIP);
        send_pixel(12'd4095, 12'd0);
        drain();
        set_view(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd1, 32'd4096, 32'd5,
                 VAR_JULIA);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        drain();

        // Zero iteration limit: no step is taken, the start point comes back.
        set_view(32'd0, 32'd0, 32'h7FFFFFFF, 32'd16, 32'd16, 32'd0, VAR_JULIA);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd8, 12'd8);
        drain();

        // The full iteration limit on a point that never leaves the set.
        set_view(32'd0, 32'd0, 32'd0, 32'd1024, 32'd1024, 32'd65535, VAR_MANDEL);
        send_pixel(12'd7, 12'd9);
        drain();

        // Random part: a fresh view per phase, cycling through the idle modes.
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
                1: begin send_idle_pct = 65; pop_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  pop_stall_pct = 65; end
                default: begin send_idle_pct = 7; pop_stall_pct = 7; end
            endcase
            span_r = ($urandom_range(3) == 0) ? $urandom_range(32'h7FFFFFFF)
                                              : $urandom_range(32'h02000000, 32'h14000000);
            set_view(rand_center(), rand_center(), span_r,
                     $urandom_range(3) == 0 ? $urandom_range(8191) : $urandom_range(1, 4096),
                     $urandom_range(3) == 0 ? $urandom_range(8191) : $urandom_range(1, 4096),
                     $urandom_range(1, 48), 2'($urandom_range(3)));
            for (int n = 0; n < 100; n++)
                send_pixel(12'($urandom()), 12'($urandom()));
            drain();
        end

        if (sb.errors == 0)
            $display("escape_time_fractal_iterator_core regression: pass");
        else
            $display("escape_time_fractal_iterator_core regression: fail");
        $finish;
    end
endmodule
